>>> hdl/palette_scale_bayer_mono_dither_macros.svh
// Assertion macros for the palette to mono converter.
`ifndef PALETTE_SCALE_BAYER_MONO_DITHER_MACROS_SVH
`define PALETTE_SCALE_BAYER_MONO_DITHER_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define PSBMD_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("psbmd check failed");

// Check that cons holds in the cycle after ante.
`define PSBMD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("psbmd check failed");

`endif

>>> hdl/psbmd_pkg.sv
// Types, constants and helper functions of the palette to mono converter.
package psbmd_pkg;

  // Largest output dimension honored by the scaler
  localparam int unsigned MAX_DIM   = 512;
  localparam int unsigned DIM_LIMIT = (MAX_DIM < 512) ? MAX_DIM : 512;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 10;

  localparam int unsigned Q_DEPTH = 2;
  localparam int unsigned Q_PTR_W = 1;
  localparam int unsigned Q_CNT_W = 2;

  typedef enum logic [1:0] {
    REQ_PALETTE = 2'd0,
    REQ_FRAME   = 2'd1,
    REQ_EMIT    = 2'd2,
    REQ_NONE    = 2'd3
  } req_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PIXEL_FORMAT = 3'd0,
    CFG_SRC_WIDTH    = 3'd1,
    CFG_SRC_HEIGHT   = 3'd2,
    CFG_SRC_STRIDE   = 3'd3,
    CFG_OUT_WIDTH    = 3'd4,
    CFG_OUT_HEIGHT   = 3'd5
  } cfg_idx_e;

  typedef enum logic [1:0] {
    B_IDLE,
    B_BASE,
    B_PIX,
    B_DRAIN
  } back_state_e;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [7:0]  palette_index;
    logic [15:0] palette_color;
    logic [16:0] frame_addr;
    logic [7:0]  frame_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] mono_byte;
    logic [8:0] out_row;
    logic [5:0] out_byte_col;
    logic       frame_last;
  } out_item_t;

  typedef struct packed {
    logic       pixel_format;
    logic [9:0] src_width;
    logic [9:0] src_height;
    logic [9:0] src_stride;
    logic [9:0] out_width;
    logic [9:0] out_height;
  } cfg_t;

  // Classified command as held in the queue
  typedef struct packed {
    req_e        kind;
    logic [7:0]  pal_index;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [16:0] frame_addr;
    logic [7:0]  frame_byte;
  } cmd_t;

  typedef struct packed {
    logic [Q_CNT_W-1:0] count;
    logic               empty;
    logic               full;
  } q_stat_t;

  typedef struct packed {
    logic idle;
    logic pop;
  } back_stat_t;

  // Scale a 5-bit channel to 0..255: floor(c*255/31) by reciprocal multiply
  function automatic logic [7:0] scale5(input logic [4:0] c);
    logic [12:0] x;
    logic [29:0] p;
    x = {c, 8'b0} - {8'b0, c};
    p = {17'b0, x} * 30'd33826;
    return p[27:20];
  endfunction

  // Scale a 6-bit channel to 0..255: floor(c*255/63) by reciprocal multiply
  function automatic logic [7:0] scale6(input logic [5:0] c);
    logic [13:0] x;
    logic [29:0] p;
    x = {c, 8'b0} - {8'b0, c};
    p = {16'b0, x} * 30'd16645;
    return p[27:20];
  endfunction

  // Clamp an output dimension: zero counts as one, large values saturate
  function automatic logic [9:0] limit_dim(input logic [9:0] v);
    logic [9:0] lim;
    lim = 10'(DIM_LIMIT);
    if (v == 10'd0) begin
      return 10'd1;
    end else if (v > lim) begin
      return lim;
    end
    return v;
  endfunction

  // 4x4 ordered dither threshold
  function automatic logic [3:0] bayer(input logic [1:0] row, input logic [1:0] col);
    logic [3:0] t;
    case ({row, col})
      4'h0: t = 4'd0;
      4'h1: t = 4'd8;
      4'h2: t = 4'd2;
      4'h3: t = 4'd10;
      4'h4: t = 4'd12;
      4'h5: t = 4'd4;
      4'h6: t = 4'd14;
      4'h7: t = 4'd6;
      4'h8: t = 4'd3;
      4'h9: t = 4'd11;
      4'hA: t = 4'd1;
      4'hB: t = 4'd9;
      4'hC: t = 4'd15;
      4'hD: t = 4'd7;
      4'hE: t = 4'd13;
      4'hF: t = 4'd5;
      default: t = 4'd0;
    endcase
    return t;
  endfunction

endpackage

>>> hdl/psbmd_front.sv
// Front end: accepts request beats, classifies them and pre-scales palette colors.
module psbmd_front (
  input  logic                start,
  output logic                busy,
  input  psbmd_pkg::in_item_t req_i,
  input  psbmd_pkg::q_stat_t  q_stat_i,
  output logic                push_o,
  output psbmd_pkg::cmd_t     cmd_o
);

  // Stall the requester only when the queue has no room
  assign busy   = q_stat_i.full;
  assign push_o = start && !q_stat_i.full;

  // Decode the request and expand RGB565 into 8-bit channels
  always_comb begin
    cmd_o.kind       = psbmd_pkg::req_e'(req_i.req_type);
    cmd_o.pal_index  = req_i.palette_index;
    cmd_o.red        = psbmd_pkg::scale5(req_i.palette_color[15:11]);
    cmd_o.green      = psbmd_pkg::scale6(req_i.palette_color[10:5]);
    cmd_o.blue       = psbmd_pkg::scale5(req_i.palette_color[4:0]);
    cmd_o.frame_addr = req_i.frame_addr;
    cmd_o.frame_byte = req_i.frame_byte;
  end

endmodule

>>> hdl/psbmd_queue.sv
// Short command queue between the front end and the back end.
module psbmd_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  psbmd_pkg::cmd_t    cmd_i,
  input  logic               pop_i,
  output psbmd_pkg::cmd_t    head_o,
  output psbmd_pkg::q_stat_t stat_o
);

  psbmd_pkg::cmd_t                      entry_q [psbmd_pkg::Q_DEPTH];
  logic [psbmd_pkg::Q_PTR_W-1:0]        wptr_q, wptr_d;
  logic [psbmd_pkg::Q_PTR_W-1:0]        rptr_q, rptr_d;
  logic [psbmd_pkg::Q_CNT_W-1:0]        count_q, count_d;

  // Advance pointers and the fill count
  always_comb begin
    wptr_d  = push_i ? wptr_q + 1'b1 : wptr_q;
    rptr_d  = pop_i ? rptr_q + 1'b1 : rptr_q;
    count_d = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  // Store the incoming beat
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wptr_q] <= cmd_i;
    end
  end

  assign head_o       = entry_q[rptr_q];
  assign stat_o.count = count_q;
  assign stat_o.empty = (count_q == '0);
  assign stat_o.full  = (count_q == psbmd_pkg::Q_CNT_W'(psbmd_pkg::Q_DEPTH));

endmodule

>>> hdl/psbmd_back.sv
// Back end: palette and frame stores, scaler state and the per-pixel dither pipeline.
module psbmd_back #(
  parameter int unsigned FRAME_BYTES = 131072
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  psbmd_pkg::cfg_t       cfg_i,
  input  psbmd_pkg::cmd_t       head_i,
  input  psbmd_pkg::q_stat_t    q_stat_i,
  output logic                  pop_o,
  output logic                  res_valid_o,
  output psbmd_pkg::out_item_t  res_o,
  output psbmd_pkg::back_stat_t stat_o
);

  localparam int unsigned ADDR_W = $clog2(FRAME_BYTES);

  psbmd_pkg::back_state_e state_q, state_d;

  // Stores
  logic [7:0]   frame_mem [FRAME_BYTES];
  logic [7:0]   luma_mem  [256];
  logic [255:0] luma_vld_q;
  logic [7:0]   frame_rd_q;
  logic [7:0]   luma_rd_q;
  logic         luma_rdv_q;

  // Scaler state
  logic [8:0]  row_q;
  logic [5:0]  colb_q;
  logic [8:0]  src_row_q;
  logic [9:0]  row_acc_q;
  logic [8:0]  src_col_q;
  logic [9:0]  col_acc_q;
  logic [18:0] base_q;
  logic [2:0]  n_q;
  logic [7:0]  mono_q;

  // Pixel pipeline
  logic       s1_valid_q;
  logic [2:0] s1_n_q;
  logic [1:0] s1_sub_q;
  logic       s2_valid_q;
  logic [2:0] s2_n_q;
  logic [7:0] s2_dark0_q;

  // Result register
  logic                 res_valid_q;
  psbmd_pkg::out_item_t res_q;

  // Control strobes
  logic lwe, fwe, issue, done, start_emit;

  // Combinational datapath
  logic [9:0]        w, h;
  logic [9:0]        x;
  logic              pix_ok;
  logic [10:0]       col_sum, col_sub;
  logic              col_wrap;
  logic [8:0]        rd_off;
  logic [19:0]       rd_sum;
  logic [19:0]       wr_ext;
  logic [ADDR_W-1:0] frame_addr;
  logic [15:0]       luma_sum;
  logic [7:0]        luma_w;
  logic [10:0]       w_plus;
  logic [6:0]        row_bytes;
  logic              last_col, last_row;
  logic [10:0]       row_sum, row_sub;
  logic              row_wrap;
  logic [7:0]        shifted;
  logic [7:0]        dark0;
  logic [7:0]        luma_eff;
  logic [7:0]        dark;
  logic [7:0]        thr;

  assign w = psbmd_pkg::limit_dim(cfg_i.out_width);
  assign h = psbmd_pkg::limit_dim(cfg_i.out_height);

  // Column step for the pixel at the head of the issue loop
  assign x        = {1'b0, colb_q, n_q};
  assign pix_ok   = (x < w);
  assign col_sum  = {1'b0, col_acc_q} + {1'b0, cfg_i.src_width};
  assign col_wrap = (col_sum >= {1'b0, w});
  assign col_sub  = col_wrap ? col_sum - {1'b0, w} : col_sum;

  // Source address of the current pixel, wrapped to the store size
  assign rd_off     = cfg_i.pixel_format ? src_col_q : {2'b0, src_col_q[8:2]};
  assign rd_sum     = {1'b0, base_q} + {11'b0, rd_off};
  assign wr_ext     = {3'b0, head_i.frame_addr};
  assign frame_addr = fwe ? wr_ext[ADDR_W-1:0] : rd_sum[ADDR_W-1:0];

  // Luma of a palette load
  assign luma_sum = {8'b0, head_i.red} * 16'd77 + {8'b0, head_i.green} * 16'd150
                  + {8'b0, head_i.blue} * 16'd29;
  assign luma_w   = luma_sum[15:8];

  // Row and frame end
  assign w_plus    = {1'b0, w} + 11'd7;
  assign row_bytes = w_plus[9:3];
  assign last_col  = ({1'b0, colb_q} + 7'd1) >= row_bytes;
  assign last_row  = ({1'b0, row_q} + 10'd1) >= h;
  assign row_sum   = {1'b0, row_acc_q} + {1'b0, cfg_i.src_height};
  assign row_wrap  = (row_sum >= {1'b0, h});
  assign row_sub   = row_wrap ? row_sum - {1'b0, h} : row_sum;

  // Darkness of a 2-bit packed pixel
  assign shifted = frame_rd_q >> {s1_sub_q, 1'b0};
  assign dark0   = {6'b0, shifted[1:0]} * 8'd85;

  // Darkness and threshold of the pixel leaving the pipeline
  assign luma_eff = luma_rdv_q ? luma_rd_q : 8'd0;
  assign dark     = cfg_i.pixel_format ? 8'd255 - luma_eff : s2_dark0_q;
  assign thr      = {psbmd_pkg::bayer(row_q[1:0], s2_n_q[1:0]), 4'b0};

  // Next state and control strobes
  always_comb begin
    state_d    = state_q;
    pop_o      = 1'b0;
    lwe        = 1'b0;
    fwe        = 1'b0;
    issue      = 1'b0;
    done       = 1'b0;
    start_emit = 1'b0;
    case (state_q)
      psbmd_pkg::B_IDLE: begin
        if (!q_stat_i.empty) begin
          pop_o = 1'b1;
          case (head_i.kind)
            psbmd_pkg::REQ_PALETTE: lwe = 1'b1;
            psbmd_pkg::REQ_FRAME:   fwe = 1'b1;
            psbmd_pkg::REQ_EMIT:    state_d = psbmd_pkg::B_BASE;
            default: ;
          endcase
        end
      end
      psbmd_pkg::B_BASE: begin
        start_emit = 1'b1;
        state_d    = psbmd_pkg::B_PIX;
      end
      psbmd_pkg::B_PIX: begin
        if (pix_ok) begin
          issue = 1'b1;
          if (n_q == 3'd7) begin
            state_d = psbmd_pkg::B_DRAIN;
          end
        end else begin
          state_d = psbmd_pkg::B_DRAIN;
        end
      end
      psbmd_pkg::B_DRAIN: begin
        if (!s1_valid_q && !s2_valid_q) begin
          done    = 1'b1;
          state_d = psbmd_pkg::B_IDLE;
        end
      end
      default: state_d = psbmd_pkg::B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= psbmd_pkg::B_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Frame store: one port, write or read in a cycle
  always_ff @(posedge clk_i) begin
    if (fwe) begin
      frame_mem[frame_addr] <= head_i.frame_byte;
    end else begin
      frame_rd_q <= frame_mem[frame_addr];
    end
  end

  // Luma table: loads write, the pixel pipeline reads
  always_ff @(posedge clk_i) begin
    if (lwe) begin
      luma_mem[head_i.pal_index] <= luma_w;
    end
    luma_rd_q <= luma_mem[frame_rd_q];
  end

  // Luma valid bits: an unloaded entry reads as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      luma_vld_q <= '0;
      luma_rdv_q <= 1'b0;
    end else begin
      if (lwe) begin
        luma_vld_q[head_i.pal_index] <= 1'b1;
      end
      luma_rdv_q <= luma_vld_q[frame_rd_q];
    end
  end

  // Pixel pipeline control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= issue;
      s2_valid_q <= s1_valid_q;
    end
  end

  // Pixel pipeline payload
  always_ff @(posedge clk_i) begin
    s1_n_q     <= n_q;
    s1_sub_q   <= src_col_q[1:0];
    s2_n_q     <= s1_n_q;
    s2_dark0_q <= dark0;
    if (start_emit) begin
      base_q <= {10'b0, src_row_q} * {9'b0, cfg_i.src_stride};
    end
  end

  // Scaler counters, accumulators and the mono byte under construction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q     <= '0;
      colb_q    <= '0;
      src_row_q <= '0;
      row_acc_q <= '0;
      src_col_q <= '0;
      col_acc_q <= '0;
      n_q       <= '0;
      mono_q    <= '0;
    end else begin
      if (start_emit) begin
        n_q    <= '0;
        mono_q <= '0;
      end
      if (issue) begin
        n_q       <= n_q + 3'd1;
        col_acc_q <= col_sub[9:0];
        if (col_wrap) begin
          src_col_q <= src_col_q + 9'd1;
        end
      end
      if (s2_valid_q && (thr < dark)) begin
        mono_q[s2_n_q] <= 1'b1;
      end
      if (done) begin
        if (last_col) begin
          src_col_q <= '0;
          col_acc_q <= '0;
          colb_q    <= '0;
          if (last_row) begin
            src_row_q <= '0;
            row_acc_q <= '0;
            row_q     <= '0;
          end else begin
            row_acc_q <= row_sub[9:0];
            if (row_wrap) begin
              src_row_q <= src_row_q + 9'd1;
            end
            row_q <= row_q + 9'd1;
          end
        end else begin
          colb_q <= colb_q + 6'd1;
        end
      end
    end
  end

  // Result strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= done;
    end
  end

  // Result beat payload
  always_ff @(posedge clk_i) begin
    if (done) begin
      res_q.mono_byte    <= mono_q;
      res_q.out_row      <= row_q;
      res_q.out_byte_col <= colb_q;
      res_q.frame_last   <= last_col && last_row;
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;
  assign stat_o.idle = (state_q == psbmd_pkg::B_IDLE);
  assign stat_o.pop  = pop_o;

endmodule

>>> hdl/palette_scale_bayer_mono_dither.sv
// Operation: an emit beat is popped from the queue, the row base is multiplied out, then up to
// eight single-port frame store reads issue (fewer for a byte that ends past the row width) and
// the pixel pipeline drains before the result strobe; loads and frame writes are done from idle.
// An emit holds the back end until its result; the queue keeps taking beats until it is full.
// Reset: asynchronous, clears registers, counters, the two-entry queue and palette valid bits
// (unloaded entries read as luma zero); the frame store is not cleared.
`include "palette_scale_bayer_mono_dither_macros.svh"

module palette_scale_bayer_mono_dither #(
  parameter int unsigned FRAME_BYTES = 131072
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start,
  output logic                                 busy,
  input  psbmd_pkg::in_item_t                  req_i,
  input  logic                                 cfg_we_i,
  input  logic [psbmd_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [psbmd_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  output logic                                 res_valid_o,
  output psbmd_pkg::out_item_t                 res_o
);

  psbmd_pkg::cfg_t       cfg_q;
  psbmd_pkg::cmd_t       push_cmd;
  psbmd_pkg::cmd_t       head_cmd;
  psbmd_pkg::q_stat_t    q_stat;
  psbmd_pkg::back_stat_t bk_stat;
  logic                  push;
  logic                  pop;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pixel_format <= 1'b1;
      cfg_q.src_width    <= 10'd1;
      cfg_q.src_height   <= 10'd1;
      cfg_q.src_stride   <= 10'd1;
      cfg_q.out_width    <= 10'd1;
      cfg_q.out_height   <= 10'd1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        psbmd_pkg::CFG_PIXEL_FORMAT: cfg_q.pixel_format <= cfg_data_i[0];
        psbmd_pkg::CFG_SRC_WIDTH:    cfg_q.src_width    <= cfg_data_i;
        psbmd_pkg::CFG_SRC_HEIGHT:   cfg_q.src_height   <= cfg_data_i;
        psbmd_pkg::CFG_SRC_STRIDE:   cfg_q.src_stride   <= cfg_data_i;
        psbmd_pkg::CFG_OUT_WIDTH:    cfg_q.out_width    <= cfg_data_i;
        psbmd_pkg::CFG_OUT_HEIGHT:   cfg_q.out_height   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  psbmd_front u_front (
    .start    (start),
    .busy     (busy),
    .req_i    (req_i),
    .q_stat_i (q_stat),
    .push_o   (push),
    .cmd_o    (push_cmd)
  );

  psbmd_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .cmd_i  (push_cmd),
    .pop_i  (pop),
    .head_o (head_cmd),
    .stat_o (q_stat)
  );

  psbmd_back #(
    .FRAME_BYTES (FRAME_BYTES)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .head_i      (head_cmd),
    .q_stat_i    (q_stat),
    .pop_o       (pop),
    .res_valid_o (res_valid_o),
    .res_o       (res_o),
    .stat_o      (bk_stat)
  );

  // Results leave only as the back end returns to idle
  `PSBMD_ASSERT_NOW(a_res_when_idle, res_valid_o, bk_stat.idle)
  // A result strobe lasts one cycle and is never followed directly by another
  `PSBMD_ASSERT_NEXT(a_res_single, res_valid_o, !res_valid_o)
  // Never pop an empty queue
  `PSBMD_ASSERT_NOW(a_pop_nonempty, bk_stat.pop, !q_stat.empty)
  // Fill count stays within the queue depth
  `PSBMD_ASSERT_NOW(a_q_bound, 1'b1, q_stat.count <= psbmd_pkg::Q_CNT_W'(psbmd_pkg::Q_DEPTH))

endmodule

>>> bench/palette_scale_bayer_mono_dither_tb.sv
// Self-checking bench for the palette to mono dither converter with a built-in predictor.
`timescale 1ns / 100ps

module palette_scale_bayer_mono_dither_tb;

  localparam int FRAME_BYTES   = 131072;
  localparam int RANDOM_BEATS  = 1450;
  localparam int SETTLE_CYCLES = 40;
  localparam longint TIMEOUT_NS = 64'd30_000_000;
  // 4x4 ordered dither thresholds, nibble i is entry (row*4 + col)
  localparam logic [63:0] BAYER_4X4 = 64'h5D7F_91B3_6E4C_A280;

  logic                                clk_i;
  logic                                rst_ni;
  logic                                start;
  logic                                busy;
  psbmd_pkg::in_item_t                 req_i;
  logic                                cfg_we_i;
  logic [psbmd_pkg::CFG_IDX_W-1:0]     cfg_idx_i;
  logic [psbmd_pkg::CFG_DATA_W-1:0]    cfg_data_i;
  logic                                res_valid_o;
  psbmd_pkg::out_item_t                res_o;

  // Predictor registers and stores
  int fmt_q = 1;
  int sw_q = 1;
  int sh_q = 1;
  int stride_q = 1;
  int ow_q = 1;
  int oh_q = 1;
  bit [7:0] luma_mem [256];
  bit [7:0] frame_mem [FRAME_BYTES];
  bit       frame_written [FRAME_BYTES];
  int row_cnt = 0;
  int byte_cnt = 0;
  int srow = 0;
  int racc = 0;
  int scol = 0;
  int cacc = 0;
  int read_addrs[$];

  psbmd_pkg::out_item_t pending_mono[$];
  psbmd_pkg::out_item_t want_item;
  int  mismatches = 0;
  int  beats_sent = 0;
  bit  no_gaps = 1'b0;

  palette_scale_bayer_mono_dither #(
    .FRAME_BYTES(FRAME_BYTES)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .req_i      (req_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .res_valid_o(res_valid_o),
    .res_o      (res_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("Verification failed");
    $finish;
  end

  // ---------------------------------------------------------------- predictor

  function automatic int clamp_dim(int v);
    if (v == 0) return 1;
    if (v > int'(psbmd_pkg::DIM_LIMIT)) return int'(psbmd_pkg::DIM_LIMIT);
    return v;
  endfunction

  function automatic int color_luma(int c);
    int r, g, b;
    r = ((c >> 11) & 'h1F) * 255 / 31;
    g = ((c >> 5) & 'h3F) * 255 / 63;
    b = (c & 'h1F) * 255 / 31;
    return ((r * 77 + g * 150 + b * 29) >> 8) & 'hFF;
  endfunction

  function automatic int frame_addr_of(int row, int col);
    int off;
    off = (fmt_q == 0) ? (col >> 2) : col;
    return (row * stride_q + off) % FRAME_BYTES;
  endfunction

  // Work out the next mono byte; advance the scan state only when commit is set.
  // The frame addresses it reads are left in read_addrs.
  function automatic psbmd_pkg::out_item_t mono_from_frame(input bit commit);
    int w, h, row_bytes, row, col, x, n, sum, c, cacc_l, mono, dark, a, thr;
    bit lc, lr;
    psbmd_pkg::out_item_t r;
    w = clamp_dim(ow_q);
    h = clamp_dim(oh_q);
    row_bytes = (w + 7) / 8;
    row = row_cnt;
    col = byte_cnt;
    c = scol;
    cacc_l = cacc;
    mono = 0;
    read_addrs.delete();
    for (n = 0; n < 8; n++) begin
      x = col * 8 + n;
      // padding pixels stay light and do not step the column
      if (x < w) begin
        a = frame_addr_of(srow, c);
        read_addrs.push_back(a);
        if (fmt_q == 0) begin
          dark = ((frame_mem[a] >> ((c & 3) * 2)) & 3) * 85;
        end else begin
          dark = 255 - int'(luma_mem[frame_mem[a]]);
        end
        thr = int'(BAYER_4X4[4 * ((row & 3) * 4 + (x & 3)) +: 4]);
        if (thr * 16 < dark) mono |= (1 << n);
        sum = cacc_l + sw_q;
        if (sum >= w) begin
          sum -= w;
          c = (c + 1) & 'h1FF;
        end
        cacc_l = sum & 'h3FF;
      end
    end
    lc = (col + 1 >= row_bytes);
    lr = (row + 1 >= h);
    r.mono_byte    = 8'(mono);
    r.out_row      = 9'(row);
    r.out_byte_col = 6'(col);
    r.frame_last   = lc && lr;
    if (commit) begin
      scol = c;
      cacc = cacc_l;
      if (lc) begin
        scol = 0;
        cacc = 0;
        byte_cnt = 0;
        if (lr) begin
          srow = 0;
          racc = 0;
          row_cnt = 0;
        end else begin
          sum = racc + sh_q;
          if (sum >= h) begin
            sum -= h;
            srow = (srow + 1) & 'h1FF;
          end
          racc = sum & 'h3FF;
          row_cnt = (row + 1) & 'h1FF;
        end
      end else begin
        byte_cnt = (col + 1) & 'h3F;
      end
    end
    return r;
  endfunction

  // Update the predictor for one accepted beat
  function automatic void predict_beat(psbmd_pkg::in_item_t it);
    case (it.req_type)
      psbmd_pkg::REQ_PALETTE:
        luma_mem[it.palette_index] = 8'(color_luma(int'(it.palette_color)));
      psbmd_pkg::REQ_FRAME: begin
        frame_mem[it.frame_addr % FRAME_BYTES] = it.frame_byte;
        frame_written[it.frame_addr % FRAME_BYTES] = 1'b1;
      end
      psbmd_pkg::REQ_EMIT: pending_mono.push_back(mono_from_frame(1'b1));
      default: ;
    endcase
  endfunction

  // ---------------------------------------------------------------- drivers

  function automatic psbmd_pkg::in_item_t random_beat(psbmd_pkg::req_e kind);
    psbmd_pkg::in_item_t it;
    it.req_type      = kind;
    it.palette_index = 8'($urandom);
    it.palette_color = 16'($urandom);
    it.frame_addr    = 17'($urandom);
    it.frame_byte    = 8'($urandom);
    return it;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Send one beat and hold it until the block takes it
  task automatic send_beat(input psbmd_pkg::in_item_t it);
    int gap;
    gap = no_gaps ? 0 : pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start <= 1'b1;
    req_i <= it;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    predict_beat(it);
    if (it.req_type != psbmd_pkg::REQ_NONE) beats_sent++;
  endtask

  task automatic load_palette(int idx, int color);
    psbmd_pkg::in_item_t it;
    it = random_beat(psbmd_pkg::REQ_PALETTE);
    it.palette_index = 8'(idx);
    it.palette_color = 16'(color);
    send_beat(it);
  endtask

  task automatic write_frame(int addr, int value);
    psbmd_pkg::in_item_t it;
    it = random_beat(psbmd_pkg::REQ_FRAME);
    it.frame_addr = 17'(addr);
    it.frame_byte = 8'(value);
    send_beat(it);
  endtask

  // Fill every frame byte the next emit will read, then send the emit
  task automatic emit_byte();
    int addrs[$];
    void'(mono_from_frame(1'b0));
    addrs = read_addrs;
    foreach (addrs[i]) begin
      if (!frame_written[addrs[i]]) write_frame(addrs[i], $urandom_range(0, 255));
    end
    send_beat(random_beat(psbmd_pkg::REQ_EMIT));
  endtask

  // Pause the sender until every expected beat is back and the queue has drained
  task automatic wait_drained();
    start <= 1'b0;
    @(posedge clk_i);
    while (pending_mono.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Drive one register write; the caller drops the write enable afterwards
  task automatic write_reg(psbmd_pkg::cfg_idx_e idx, int value);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= 10'(value);
    @(posedge clk_i);
    case (idx)
      psbmd_pkg::CFG_PIXEL_FORMAT: fmt_q    = value & 1;
      psbmd_pkg::CFG_SRC_WIDTH:    sw_q     = value & 'h3FF;
      psbmd_pkg::CFG_SRC_HEIGHT:   sh_q     = value & 'h3FF;
      psbmd_pkg::CFG_SRC_STRIDE:   stride_q = value & 'h3FF;
      psbmd_pkg::CFG_OUT_WIDTH:    ow_q     = value & 'h3FF;
      psbmd_pkg::CFG_OUT_HEIGHT:   oh_q     = value & 'h3FF;
      default: ;
    endcase
  endtask

  task automatic apply_config(int fmt, int sw, int sh, int stride, int ow, int oh);
    wait_drained();
    write_reg(psbmd_pkg::CFG_PIXEL_FORMAT, fmt);
    write_reg(psbmd_pkg::CFG_SRC_WIDTH, sw);
    write_reg(psbmd_pkg::CFG_SRC_HEIGHT, sh);
    write_reg(psbmd_pkg::CFG_SRC_STRIDE, stride);
    write_reg(psbmd_pkg::CFG_OUT_WIDTH, ow);
    write_reg(psbmd_pkg::CFG_OUT_HEIGHT, oh);
    cfg_we_i <= 1'b0;
  endtask

  // ---------------------------------------------------------------- checker

  task automatic flag_mismatch(string what, logic [15:0] got, logic [15:0] want);
    $display("%0t: mono beat mismatch on %s: got %0h, want %0h", $time, what, got, want);
    mismatches++;
  endtask

  // Compare every result beat with the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && res_valid_o) begin
      if (pending_mono.size() == 0) begin
        flag_mismatch("unexpected beat", 16'(res_o), 16'h0);
      end else begin
        want_item = pending_mono.pop_front();
        if (res_o.mono_byte !== want_item.mono_byte)
          flag_mismatch("mono_byte", 16'(res_o.mono_byte), 16'(want_item.mono_byte));
        if (res_o.out_row !== want_item.out_row)
          flag_mismatch("out_row", 16'(res_o.out_row), 16'(want_item.out_row));
        if (res_o.out_byte_col !== want_item.out_byte_col)
          flag_mismatch("out_byte_col", 16'(res_o.out_byte_col),
                        16'(want_item.out_byte_col));
        if (res_o.frame_last !== want_item.frame_last)
          flag_mismatch("frame_last", 16'(res_o.frame_last), 16'(want_item.frame_last));
      end
    end
  end

  // ---------------------------------------------------------------- tests

  // Emit with reset registers and an all-zero luma table
  task automatic test_reset_state();
    emit_byte();
    emit_byte();
  endtask

  // Black, white and pure red palette entries through the luma path
  task automatic test_palette_luma();
    apply_config(1, 3, 1, 3, 8, 1);
    load_palette(0, 16'h0000);
    load_palette(255, 16'hFFFF);
    load_palette(1, 16'hF800);
    write_frame(0, 0);
    write_frame(1, 255);
    write_frame(2, 1);
    emit_byte();
  endtask

  // Fixed ramp with all four packed indices, padding bits in the second byte
  task automatic test_two_bit_ramp();
    apply_config(0, 4, 1, 1, 13, 1);
    write_frame(0, 8'hE4);
    emit_byte();
    emit_byte();
  endtask

  // Zero and oversize output dimensions, then output smaller than source
  task automatic test_size_limits();
    apply_config(1, 2, 2, 2, 0, 0);
    emit_byte();
    apply_config(0, 512, 1, 512, 1023, 1023);
    emit_byte();
    emit_byte();
    apply_config(0, 20, 4, 20, 8, 2);
    emit_byte();
    emit_byte();
  endtask

  // The unused request code and the top of the frame address range
  task automatic test_unused_request();
    send_beat(random_beat(psbmd_pkg::REQ_NONE));
    send_beat(random_beat(psbmd_pkg::REQ_NONE));
    write_frame(FRAME_BYTES - 1, 8'hFF);
  endtask

  function automatic int extreme_dim();
    return ($urandom_range(0, 1) != 0) ? 512 : 1;
  endfunction

  // Phases of random settings with mixed loads, writes, emits and noise
  task automatic test_random_traffic();
    int first, mode, steps, pick, fmt, sw, sh, stride, ow, oh, phase;
    first = beats_sent;
    phase = 0;
    while (beats_sent - first < RANDOM_BEATS) begin
      no_gaps = ($urandom_range(0, 4) == 0);
      mode = (phase == 1) ? 8 : $urandom_range(0, 9);
      steps = $urandom_range(10, 60);
      fmt = $urandom_range(0, 1);
      sw = $urandom_range(1, 16);
      sh = $urandom_range(1, 12);
      stride = $urandom_range(1, 48);
      ow = ($urandom_range(0, 3) == 0) ? $urandom_range(1, sw) : $urandom_range(sw, sw + 40);
      oh = ($urandom_range(0, 3) == 0) ? $urandom_range(1, sh) : $urandom_range(sh, sh + 10);
      case (mode)
        6: begin
          sw = $urandom_range(256, 512);
          sh = $urandom_range(1, 512);
          stride = $urandom_range(256, 512);
          ow = ($urandom_range(0, 1) != 0) ? 512 : 1023;
          oh = 512;
          steps = $urandom_range(20, 40);
        end
        7: begin
          sw = extreme_dim();
          sh = extreme_dim();
          stride = extreme_dim();
          ow = extreme_dim();
          oh = extreme_dim();
          steps = $urandom_range(20, 40);
        end
        // tall narrow frame so row*stride wraps the frame store
        8: begin
          sw = $urandom_range(1, 4);
          sh = 512;
          stride = 512;
          ow = $urandom_range(1, 8);
          oh = 512;
          steps = 300;
        end
        default: ;
      endcase
      if (mode == 9) begin
        // resize the output only; the scan counters carry over
        wait_drained();
        write_reg(psbmd_pkg::CFG_OUT_WIDTH, $urandom_range(1, 64));
        write_reg(psbmd_pkg::CFG_OUT_HEIGHT, $urandom_range(1, 16));
        cfg_we_i <= 1'b0;
      end else begin
        apply_config(fmt, sw, sh, stride, ow, oh);
      end
      if (fmt_q == 1) begin
        repeat ($urandom_range(0, 6)) load_palette($urandom_range(0, 255), $urandom);
      end
      repeat (steps) begin
        // stop once the beat budget is spent
        if (beats_sent - first >= RANDOM_BEATS) break;
        pick = $urandom_range(0, 99);
        if (pick < 75) begin
          emit_byte();
        end else if (pick < 85) begin
          load_palette($urandom_range(0, 255), $urandom);
        end else if (pick < 92) begin
          write_frame($urandom_range(0, FRAME_BYTES - 1), $urandom_range(0, 255));
        end else if (pick < 97) begin
          send_beat(random_beat(psbmd_pkg::REQ_NONE));
        end else begin
          wait_drained();
        end
      end
      phase++;
    end
  endtask

  // ---------------------------------------------------------------- main

  initial begin
    rst_ni     <= 1'b0;
    start      <= 1'b0;
    req_i      <= '0;
    cfg_we_i   <= 1'b0;
    cfg_idx_i  <= '0;
    cfg_data_i <= '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_state();
    test_palette_luma();
    test_two_bit_ramp();
    test_size_limits();
    test_unused_request();
    test_random_traffic();

    wait_drained();
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
